@@ src/tjod_pkg.sv @@
package tjod_pkg;

    localparam logic [2:0] OP_SUBMIT = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_FINISH = 3'd2;
    localparam logic [2:0] OP_ABANDON = 3'd3;
    localparam logic [2:0] OP_TAKE   = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_BUSY   = 2'd2;
    localparam logic [1:0] ST_NONE   = 2'd3;

    // first field in the highest bits
    typedef struct packed {
        logic [63:0] payload;
        logic [31:0] gen;
        logic [31:0] num;
        logic [1:0]  kind;
        logic        cmd_ok;
        logic [2:0]  op;
    } t_cmd;

    typedef struct packed {
        logic [63:0] payload;
        logic [1:0]  kind;
        logic [31:0] gen;
        logic [31:0] num;
        logic [1:0]  status;
    } t_res;

endpackage

@@ src/tagged_job_table_oldest_dispatch_core.sv @@
// A single scan unit walks the slot tables one entry per cycle, then an
// apply step performs the update and the result is held for output; the
// block takes one command at a time, not a new one until the result leaves.
// Input is not ready while a command is in flight or a result is held.
// Reset (synchronous, active low) clears valid bits, counters and enable.
module tagged_job_table_oldest_dispatch_core #(
    parameter int SLOTS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[2:0], command_ok[3], job_kind[5:4], ticket_number[37:6],
    // ticket_generation[69:38], finish_payload[133:70], zero pad
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], out_ticket_number[33:2], out_ticket_generation[65:34],
    // out_job_kind[67:66], out_payload[131:68], zero pad
    output logic [135:0] m_axis_tdata
);
    import tjod_pkg::*;
    localparam int IW = $clog2(SLOTS+1);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_APPLY = 2'd2,
                           S_OUT = 2'd3;

    function automatic t_res mk_res(input logic [1:0] st, input logic [31:0] num,
                                    input logic [31:0] gen, input logic [1:0] kind,
                                    input logic [63:0] pay);
        t_res r;
        r.status = st;
        r.num = num;
        r.gen = gen;
        r.kind = kind;
        r.payload = pay;
        return r;
    endfunction

    logic [1:0] r_state;
    logic       r_en;
    t_cmd       r_cmd;
    t_res       r_res;
    logic [IW-1:0] r_idx;
    logic [SLOTS-1:0] r_jv, r_jrun, r_jdrop, r_dv;
    logic [31:0] r_jtag [SLOTS];
    logic [31:0] r_jgen [SLOTS];
    logic [1:0]  r_jtype [SLOTS];
    logic [63:0] r_jage [SLOTS];
    logic [31:0] r_dtag [SLOTS];
    logic [31:0] r_dgen [SLOTS];
    logic [63:0] r_ddata [SLOTS];
    logic [IW-1:0] r_live;
    logic [31:0] r_tag;
    logic [63:0] r_age;

    logic [SW-1:0] si;
    logic jhit, dhit, accept, sclear, sstep;
    logic free_f, dfree_f, old_f, jhit_f, dhit_f;
    logic [IW-1:0] free_i, dfree_i, old_i, jhit_i, dhit_i, held;
    logic [SW-1:0] fi, dfi, oi, ji, di;
    logic [31:0] ntag;
    logic [IW:0] occ;

    assign si = r_idx[SW-1:0];
    assign jhit = r_jv[si] && r_jtag[si] == r_cmd.num && r_jgen[si] == r_cmd.gen;
    assign dhit = r_dv[si] && r_dtag[si] == r_cmd.num && r_dgen[si] == r_cmd.gen;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign sclear = accept;
    assign sstep = (r_state == S_SCAN);

    tjod_scan #(.SLOTS(SLOTS)) u_scan (
        .i_clk, .i_clear(sclear), .i_step(sstep),
        .i_job_v(r_jv[si]), .i_job_run(r_jrun[si]), .i_job_hit(jhit),
        .i_job_age(r_jage[si]), .i_done_v(r_dv[si]), .i_done_hit(dhit),
        .i_idx(r_idx),
        .o_free_f(free_f), .o_free_i(free_i), .o_dfree_f(dfree_f),
        .o_dfree_i(dfree_i), .o_old_f(old_f), .o_old_i(old_i),
        .o_jhit_f(jhit_f), .o_jhit_i(jhit_i), .o_dhit_f(dhit_f),
        .o_dhit_i(dhit_i), .o_held(held)
    );

    assign fi = free_i[SW-1:0];
    assign dfi = dfree_i[SW-1:0];
    assign oi = old_i[SW-1:0];
    assign ji = jhit_i[SW-1:0];
    assign di = dhit_i[SW-1:0];
    assign ntag = (r_tag == 32'hFFFF_FFFF) ? 32'd1 : r_tag + 32'd1;
    assign occ = {1'b0, r_live} + {1'b0, held};

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = {4'd0, r_res.payload, r_res.kind, r_res.gen, r_res.num,
                           r_res.status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_en <= 1'b0; r_idx <= '0;
            r_jv <= '0; r_jrun <= '0; r_jdrop <= '0; r_dv <= '0;
            r_live <= '0; r_tag <= '0; r_age <= '0;
        end else begin
            if (i_cfg_we) r_en <= i_cfg_wdata;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd <= s_axis_tdata[133:0];
                        r_idx <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IW'(SLOTS - 1)) r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_state <= S_OUT;
                    unique case (r_cmd.op)
                        OP_SUBMIT: begin
                            if (!r_cmd.cmd_ok)
                                r_res <= mk_res(ST_REJECT, 32'd0, 32'd0, 2'd0, 64'd0);
                            else if (!r_en || occ >= (IW+1)'(SLOTS) || !free_f)
                                r_res <= mk_res(ST_BUSY, 32'd0, 32'd0, 2'd0, 64'd0);
                            else begin
                                r_tag <= ntag; r_age <= r_age + 64'd1;
                                r_jv[fi] <= 1'b1; r_jrun[fi] <= 1'b0;
                                r_jdrop[fi] <= 1'b0;
                                r_jtag[fi] <= ntag; r_jgen[fi] <= r_cmd.gen;
                                r_jtype[fi] <= r_cmd.kind;
                                r_jage[fi] <= r_age + 64'd1;
                                r_live <= r_live + 1'b1;
                                r_res <= mk_res(ST_OK, ntag, r_cmd.gen, 2'd0, 64'd0);
                            end
                        end
                        OP_START: begin
                            if (!r_en)
                                r_res <= mk_res(ST_BUSY, 32'd0, 32'd0, 2'd0, 64'd0);
                            else if (!old_f)
                                r_res <= mk_res(ST_NONE, 32'd0, 32'd0, 2'd0, 64'd0);
                            else begin
                                r_jrun[oi] <= 1'b1;
                                r_res <= mk_res(ST_OK, r_jtag[oi], r_jgen[oi],
                                                r_jtype[oi], 64'd0);
                            end
                        end
                        OP_FINISH: begin
                            if (!jhit_f)
                                r_res <= mk_res(ST_NONE, 32'd0, 32'd0, 2'd0, 64'd0);
                            else begin
                                r_jv[ji] <= 1'b0; r_jrun[ji] <= 1'b0;
                                r_jdrop[ji] <= 1'b0;
                                if (r_live != '0) r_live <= r_live - 1'b1;
                                if (!r_jdrop[ji] && dfree_f) begin
                                    r_dv[dfi] <= 1'b1;
                                    r_dtag[dfi] <= r_jtag[ji];
                                    r_dgen[dfi] <= r_jgen[ji];
                                    r_ddata[dfi] <= r_cmd.payload;
                                end
                                r_res <= mk_res(ST_OK, 32'd0, 32'd0, 2'd0, 64'd0);
                            end
                        end
                        OP_ABANDON: begin
                            if (r_cmd.num != '0 && jhit_f) begin
                                if (r_jrun[ji]) r_jdrop[ji] <= 1'b1;
                                else begin
                                    r_jv[ji] <= 1'b0; r_jdrop[ji] <= 1'b0;
                                    if (r_live != '0) r_live <= r_live - 1'b1;
                                end
                                r_res <= mk_res(ST_OK, 32'd0, 32'd0, 2'd0, 64'd0);
                            end else if (r_cmd.num != '0 && dhit_f) begin
                                r_dv[di] <= 1'b0;
                                r_res <= mk_res(ST_OK, 32'd0, 32'd0, 2'd0, 64'd0);
                            end else begin
                                r_res <= mk_res(ST_NONE, 32'd0, 32'd0, 2'd0, 64'd0);
                            end
                        end
                        OP_TAKE: begin
                            if (r_cmd.num != '0 && dhit_f) begin
                                r_dv[di] <= 1'b0;
                                r_res <= mk_res(ST_OK, 32'd0, 32'd0, 2'd0, r_ddata[di]);
                            end else begin
                                r_res <= mk_res(ST_NONE, 32'd0, 32'd0, 2'd0, 64'd0);
                            end
                        end
                        default: r_res <= mk_res(ST_REJECT, 32'd0, 32'd0, 2'd0, 64'd0);
                    endcase
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= IW'(SLOTS)) else $error("live count overflow");
    a_run_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_jrun & ~r_jv) == '0) else $error("running bit on free slot");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while holding result");
    a_tag_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_cmd.op == OP_SUBMIT && r_res.status == ST_OK)
        |-> r_res.num != '0) else $error("zero ticket issued");
endmodule

@@ src/tjod_scan.sv @@
module tjod_scan #(
    parameter int SLOTS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_clear,
    input  logic                 i_step,
    input  logic                 i_job_v,
    input  logic                 i_job_run,
    input  logic                 i_job_hit,
    input  logic [63:0]          i_job_age,
    input  logic                 i_done_v,
    input  logic                 i_done_hit,
    input  logic [$clog2(SLOTS+1)-1:0] i_idx,
    output logic                 o_free_f,
    output logic [$clog2(SLOTS+1)-1:0] o_free_i,
    output logic                 o_dfree_f,
    output logic [$clog2(SLOTS+1)-1:0] o_dfree_i,
    output logic                 o_old_f,
    output logic [$clog2(SLOTS+1)-1:0] o_old_i,
    output logic                 o_jhit_f,
    output logic [$clog2(SLOTS+1)-1:0] o_jhit_i,
    output logic                 o_dhit_f,
    output logic [$clog2(SLOTS+1)-1:0] o_dhit_i,
    output logic [$clog2(SLOTS+1)-1:0] o_held
);
    localparam int IW = $clog2(SLOTS+1);
    logic [63:0] r_old_age;
    logic        r_free_f, r_dfree_f, r_old_f, r_jhit_f, r_dhit_f;
    logic [IW-1:0] r_free_i, r_dfree_i, r_old_i, r_jhit_i, r_dhit_i, r_held;
    logic cand;

    assign cand = i_job_v && !i_job_run && (!r_old_f || i_job_age < r_old_age);

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_free_f <= 1'b0; r_dfree_f <= 1'b0; r_old_f <= 1'b0;
            r_jhit_f <= 1'b0; r_dhit_f <= 1'b0; r_held <= '0;
        end else if (i_step) begin
            if (!i_job_v && !r_free_f) begin
                r_free_f <= 1'b1; r_free_i <= i_idx;
            end
            if (!i_done_v && !r_dfree_f) begin
                r_dfree_f <= 1'b1; r_dfree_i <= i_idx;
            end
            if (cand) begin
                r_old_f <= 1'b1; r_old_i <= i_idx; r_old_age <= i_job_age;
            end
            if (i_job_hit && !r_jhit_f) begin
                r_jhit_f <= 1'b1; r_jhit_i <= i_idx;
            end
            if (i_done_hit && !r_dhit_f) begin
                r_dhit_f <= 1'b1; r_dhit_i <= i_idx;
            end
            if (i_done_v) r_held <= r_held + 1'b1;
        end
    end

    assign o_free_f = r_free_f;   assign o_free_i = r_free_i;
    assign o_dfree_f = r_dfree_f; assign o_dfree_i = r_dfree_i;
    assign o_old_f = r_old_f;     assign o_old_i = r_old_i;
    assign o_jhit_f = r_jhit_f;   assign o_jhit_i = r_jhit_i;
    assign o_dhit_f = r_dhit_f;   assign o_dhit_i = r_dhit_i;
    assign o_held = r_held;
endmodule

@@ bench/tagged_job_table_oldest_dispatch_core_test.sv @@
`timescale 1ns / 1ps

module tagged_job_table_oldest_dispatch_core_test;
    import tjod_pkg::*;

    localparam int SLOTS = 8;
    localparam int LATENCY = SLOTS + 3;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [2:0] OP_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;

    class job_table_scoreboard;
        bit          enabled;
        bit          job_valid [SLOTS];
        bit          job_running [SLOTS];
        bit          job_dropped [SLOTS];
        logic [31:0] job_tag [SLOTS];
        logic [31:0] job_gen [SLOTS];
        logic [1:0]  job_type [SLOTS];
        logic [63:0] job_age [SLOTS];
        bit          done_valid [SLOTS];
        logic [31:0] done_tag [SLOTS];
        logic [31:0] done_gen [SLOTS];
        logic [63:0] done_data [SLOTS];
        int          jobs_live;
        logic [31:0] tag_counter;
        logic [63:0] age_counter;
        t_res        pending_results[$];
        int          errors;

        function void clear_all();
            enabled = 0;
            jobs_live = 0;
            tag_counter = 0;
            age_counter = 0;
            errors = 0;
            for (int i = 0; i < SLOTS; i++) begin
                job_valid[i] = 0;
                job_running[i] = 0;
                job_dropped[i] = 0;
                done_valid[i] = 0;
            end
        endfunction

        function int find_job(logic [31:0] num, logic [31:0] gen);
            for (int i = 0; i < SLOTS; i++)
                if (job_valid[i] && job_tag[i] == num && job_gen[i] == gen) return i;
            return -1;
        endfunction

        function int find_done(logic [31:0] num, logic [31:0] gen);
            for (int i = 0; i < SLOTS; i++)
                if (done_valid[i] && done_tag[i] == num && done_gen[i] == gen) return i;
            return -1;
        endfunction

        function void clear_slot(int i);
            job_valid[i] = 0;
            job_running[i] = 0;
            job_dropped[i] = 0;
            if (jobs_live > 0) jobs_live--;
        endfunction

        function int live_jobs();
            return jobs_live;
        endfunction

        function void note_command(t_cmd c);
            t_res r;
            int   sel;
            int   held;
            bit   was_dropped;
            r = '0;
            r.status = ST_REJECT;
            case (c.op)
                OP_SUBMIT: begin
                    held = 0;
                    sel = -1;
                    for (int i = 0; i < SLOTS; i++) if (done_valid[i]) held++;
                    for (int i = SLOTS - 1; i >= 0; i--) if (!job_valid[i]) sel = i;
                    if (!c.cmd_ok) begin
                        r.status = ST_REJECT;
                    end else if (!enabled || jobs_live + held >= SLOTS || sel < 0) begin
                        r.status = ST_BUSY;
                    end else begin
                        tag_counter++;
                        if (tag_counter == 0) tag_counter++;
                        age_counter++;
                        job_valid[sel] = 1;
                        job_running[sel] = 0;
                        job_dropped[sel] = 0;
                        job_tag[sel] = tag_counter;
                        job_gen[sel] = c.gen;
                        job_type[sel] = c.kind;
                        job_age[sel] = age_counter;
                        jobs_live++;
                        r.status = ST_OK;
                        r.num = tag_counter;
                        r.gen = c.gen;
                    end
                end
                OP_START: begin
                    if (!enabled) begin
                        r.status = ST_BUSY;
                    end else begin
                        sel = -1;
                        for (int i = 0; i < SLOTS; i++) begin
                            if (job_valid[i] && !job_running[i])
                                if (sel < 0 || job_age[i] < job_age[sel]) sel = i;
                        end
                        if (sel < 0) begin
                            r.status = ST_NONE;
                        end else begin
                            job_running[sel] = 1;
                            r.status = ST_OK;
                            r.num = job_tag[sel];
                            r.gen = job_gen[sel];
                            r.kind = job_type[sel];
                        end
                    end
                end
                OP_FINISH: begin
                    sel = find_job(c.num, c.gen);
                    if (sel < 0) begin
                        r.status = ST_NONE;
                    end else begin
                        was_dropped = job_dropped[sel];
                        clear_slot(sel);
                        if (!was_dropped) begin
                            for (int i = 0; i < SLOTS; i++) begin
                                if (!done_valid[i]) begin
                                    done_valid[i] = 1;
                                    done_tag[i] = c.num;
                                    done_gen[i] = c.gen;
                                    done_data[i] = c.payload;
                                    break;
                                end
                            end
                        end
                        r.status = ST_OK;
                    end
                end
                OP_ABANDON: begin
                    r.status = ST_NONE;
                    if (c.num != 0) begin
                        sel = find_job(c.num, c.gen);
                        if (sel >= 0) begin
                            if (job_running[sel]) job_dropped[sel] = 1;
                            else clear_slot(sel);
                            r.status = ST_OK;
                        end else begin
                            sel = find_done(c.num, c.gen);
                            if (sel >= 0) begin
                                done_valid[sel] = 0;
                                r.status = ST_OK;
                            end
                        end
                    end
                end
                OP_TAKE: begin
                    r.status = ST_NONE;
                    if (c.num != 0) begin
                        sel = find_done(c.num, c.gen);
                        if (sel >= 0) begin
                            r.payload = done_data[sel];
                            done_valid[sel] = 0;
                            r.status = ST_OK;
                        end
                    end
                end
                default: r.status = ST_REJECT;
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat %h", got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.num !== want.num) begin
                $error("out_ticket_number: expected %0h, actual %0h", want.num, got.num);
                errors++;
            end
            if (got.gen !== want.gen) begin
                $error("out_ticket_generation: expected %0h, actual %0h", want.gen, got.gen);
                errors++;
            end
            if (got.kind !== want.kind) begin
                $error("out_job_kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.payload !== want.payload) begin
                $error("out_payload: expected %0h, actual %0h", want.payload, got.payload);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_we = 0;
    logic         i_cfg_wdata = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [135:0] m_axis_tdata;

    job_table_scoreboard board;
    longint cycles = 0;
    bit     sink_hold = 0;
    bit     no_idle = 0;
    logic [31:0] issued_tickets[$];
    logic [31:0] issued_gens[$];

    tagged_job_table_oldest_dispatch_core #(.SLOTS(SLOTS)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stalls, long hold-off when asked
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_res'(m_axis_tdata[131:0]);
            board.check_result(got);
            if (m_axis_tdata[135:132] !== 4'd0) begin
                $error("pad bits: expected 0, actual %h", m_axis_tdata[135:132]);
                board.errors++;
            end
        end
        m_axis_tready <= !sink_hold && (no_idle || $urandom_range(99) >= 10);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            board.note_command(t_cmd'(s_axis_tdata[133:0]));
    end

    task automatic wait_drained();
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_enable(bit value);
        wait_drained();
        i_cfg_we <= 1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 0;
        board.enabled = value;
    endtask

    task automatic send_command(t_cmd c);
        while (!no_idle && $urandom_range(99) < 10) @(posedge i_clk);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {2'b00, c};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        s_axis_tvalid <= 0;
        @(posedge i_clk);
    endtask

    function automatic t_cmd make_cmd(logic [2:0] op, logic ok, logic [1:0] kind,
                                      logic [31:0] num, logic [31:0] gen,
                                      logic [63:0] pay);
        t_cmd c;
        c.op = op;
        c.cmd_ok = ok;
        c.kind = kind;
        c.num = num;
        c.gen = gen;
        c.payload = pay;
        return c;
    endfunction

    // mostly tickets that exist, with some noise
    function automatic t_cmd random_cmd();
        t_cmd c;
        int   pick;
        int   k;
        c = make_cmd(3'($urandom_range(4)), $urandom_range(9) != 0,
                     2'($urandom_range(3)), $urandom, $urandom,
                     {$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 3) c.op = 3'($urandom_range(7));
        else if (pick < 30) c.op = OP_SUBMIT;
        if (c.op != OP_SUBMIT && issued_tickets.size() > 0 && $urandom_range(9) < 8) begin
            k = $urandom_range(issued_tickets.size() - 1);
            c.num = issued_tickets[k];
            c.gen = issued_gens[k];
            if ($urandom_range(19) == 0) c.gen ^= 32'h1;
        end
        if ($urandom_range(9) == 0) c.gen = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_res r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            r = t_res'(m_axis_tdata[131:0]);
            if (r.status == ST_OK && r.num != 0) begin
                issued_tickets.push_back(r.num);
                issued_gens.push_back(r.gen);
                if (issued_tickets.size() > 24) begin
                    void'(issued_tickets.pop_front());
                    void'(issued_gens.pop_front());
                end
            end
        end
    end

    initial begin
        board = new();
        board.clear_all();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // disabled: submit busy, start busy, bad command rejected
        send_command(make_cmd(OP_SUBMIT, 1'b1, 2'd0, 32'd0, 32'h0, 64'd0));
        send_command(make_cmd(OP_START, 1'b0, 2'd0, 32'd0, 32'd0, 64'd0));
        send_command(make_cmd(OP_SUBMIT, 1'b0, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1));
        send_command(make_cmd(OP_UNKNOWN_LO, 1'b1, 2'd0, 32'd0, 32'd0, 64'd0));
        send_command(make_cmd(OP_UNKNOWN_HI, 1'b1, 2'd3, '1, '1, '1));
        write_enable(1'b1);
        send_command(make_cmd(OP_START, 1'b1, 2'd0, 32'd0, 32'd0, 64'd0));
        for (int i = 0; i < SLOTS + 1; i++)
            send_command(make_cmd(OP_SUBMIT, 1'b1, 2'(i), 32'd0, 32'(i * 7), 64'd0));
        wait_drained();
        for (int i = 0; i < 3; i++)
            send_command(make_cmd(OP_START, 1'b1, 2'd0, 32'd0, 32'd0, 64'd0));
        send_command(make_cmd(OP_FINISH, 1'b0, 2'd0, 32'd1, 32'd0, '1));
        send_command(make_cmd(OP_ABANDON, 1'b0, 2'd0, 32'd2, 32'd7, 64'd0));
        send_command(make_cmd(OP_FINISH, 1'b0, 2'd0, 32'd2, 32'd7, 64'h1234));
        send_command(make_cmd(OP_ABANDON, 1'b0, 2'd0, 32'd4, 32'd21, 64'd0));
        send_command(make_cmd(OP_TAKE, 1'b0, 2'd0, 32'd1, 32'd0, 64'd0));
        send_command(make_cmd(OP_TAKE, 1'b0, 2'd0, 32'd0, 32'd0, 64'd0));
        send_command(make_cmd(OP_ABANDON, 1'b0, 2'd0, 32'd0, 32'd0, 64'd0));
        send_command(make_cmd(OP_FINISH, 1'b0, 2'd0, 32'd99, 32'd0, 64'd0));

        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 1) begin
                no_idle = 1;
                fork
                    begin
                        sink_hold = 1;
                        repeat (200) @(posedge i_clk);
                        sink_hold = 0;
                    end
                join_none
            end
            if (phase == 2) no_idle = 0;
            for (int n = 0; n < 250; n++) send_command(random_cmd());
            wait_drained();
            write_enable(phase != 2);
        end

        wait_drained();
        if (board.errors == 0 && board.pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
